/* design/qccg_pkg.sv */
`timescale 1ns / 1ps

package qccg_pkg;

    localparam int KEY_COUNT   = 128;
    localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int GEN_W       = 32;
    localparam int KEYPOS_W    = 8;
    localparam int HELD_W      = 8;
    localparam int BLK_W       = 16;
    localparam int TICKS_W     = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 96;

    localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 16'd100;
    localparam logic [BLK_W-1:0]   BLK_MAX          = {BLK_W{1'b1}};
    localparam logic [KEYPOS_W-1:0] KEY_LIMIT       = KEYPOS_W'(KEY_COUNT);

    typedef enum logic [2:0] {
        CMD_REQUEST = 3'd0,
        CMD_KEY     = 3'd1,
        CMD_ACQUIRE = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_STATUS  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVAL    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [GEN_W-1:0]    new_generation;
        logic [KEYPOS_W-1:0] key_position;
        logic                key_pressed;
    } item_t;

    typedef struct packed {
        status_t             status_code;
        logic [GEN_W-1:0]    live_generation;
        logic [GEN_W-1:0]    queued_generation;
        logic [HELD_W-1:0]   pressed_count;
        logic [BLK_W-1:0]    blocker_total;
        logic                timer_running;
        logic                committed;
    } result_t;

endpackage

/* design/quiescent_config_commit_gate_core.sv */
`timescale 1ns / 1ps
// A word accepted on the slave side is held in the input register; the engine computes its
// result combinationally and the result register presents it on the master side.
// Throughput: one word per cycle while m_tready does not stall the output; the input and
// result registers let a new word enter while the previous result is still waiting to be taken.
// Reset (aresetn, synchronous, active low) clears all state, empties both registers and
// loads idle_ticks with 100.

module quiescent_config_commit_gate_core
    import qccg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // new_generation, key_position, key_pressed, zeros
    input  logic [2:0]           s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // live generation, queued generation, pressed_count, blocker total,
    // timer_running, committed, zeros
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,  // status_code
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TICKS_W-1:0]   cfg_data
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;
    logic    m_valid_reg;
    result_t m_result_reg;

    assign advance   = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    qccg_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qccg_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (item_valid && advance),
        .item     (item),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.status_code;
    assign m_tdata  = {6'd0,
                       m_result_reg.committed,
                       m_result_reg.timer_running,
                       m_result_reg.blocker_total,
                       m_result_reg.pressed_count,
                       m_result_reg.queued_generation,
                       m_result_reg.live_generation};

endmodule

/* design/qccg_in_reg.sv */
`timescale 1ns / 1ps

module qccg_in_reg
    import qccg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // new_generation, key_position, key_pressed
    input  logic [2:0]           s_tuser,   // cmd
    input  logic                 advance,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd            <= s_tuser;
            item_reg.new_generation <= s_tdata[GEN_W-1:0];
            item_reg.key_position   <= s_tdata[GEN_W+KEYPOS_W-1:GEN_W];
            item_reg.key_pressed    <= s_tdata[GEN_W+KEYPOS_W];
        end
    end

endmodule

/* design/qccg_engine.sv */
`timescale 1ns / 1ps

module qccg_engine
    import qccg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [TICKS_W-1:0] cfg_data,
    input  logic               fire,
    input  item_t              item,
    output result_t            result
);

    logic [TICKS_W-1:0]   idle_ticks_reg;
    logic [KEY_COUNT-1:0] key_map_reg;
    logic [HELD_W-1:0]    held_reg,    held_next;
    logic [BLK_W-1:0]     blk_reg,     blk_next;
    logic [GEN_W-1:0]     wait_reg,    wait_next;
    logic [GEN_W-1:0]     cur_reg,     cur_next;
    logic                 armed_reg,   armed_next;
    logic [TICKS_W-1:0]   cnt_reg,     cnt_next;
    logic                 map_we;
    logic                 map_bit_next;
    logic [KEY_IDX_W-1:0] key_idx;
    logic                 key_bit;
    status_t              status;
    logic                 committed;

    assign key_idx = item.key_position[KEY_IDX_W-1:0];
    assign key_bit = key_map_reg[key_idx];

    always_comb begin
        held_next    = held_reg;
        blk_next     = blk_reg;
        wait_next    = wait_reg;
        cur_next     = cur_reg;
        armed_next   = armed_reg;
        cnt_next     = cnt_reg;
        map_we       = 1'b0;
        map_bit_next = item.key_pressed;
        status       = ST_OK;
        committed    = 1'b0;
        case (cmd_t'(item.cmd))
            CMD_REQUEST: begin
                if (item.new_generation == '0) begin
                    status = ST_INVAL;
                end else begin
                    wait_next = (item.new_generation == cur_reg) ? '0 : item.new_generation;
                    if (wait_next != '0 && held_reg == '0 && blk_reg == '0) begin
                        armed_next = 1'b1;
                        cnt_next   = idle_ticks_reg;
                    end
                end
            end
            CMD_KEY: begin
                if (item.key_position >= KEY_LIMIT) begin
                    status = ST_INVAL;
                end else begin
                    if (item.key_pressed && !key_bit) begin
                        map_we    = 1'b1;
                        held_next = held_reg + HELD_W'(1);
                    end else if (!item.key_pressed && key_bit) begin
                        map_we    = 1'b1;
                        held_next = held_reg - HELD_W'(1);
                    end
                    if (item.key_pressed) begin
                        armed_next = 1'b0;
                    end else if (wait_reg != '0 && held_next == '0 && blk_reg == '0) begin
                        armed_next = 1'b1;
                        cnt_next   = idle_ticks_reg;
                    end
                end
            end
            CMD_ACQUIRE: begin
                if (blk_reg == BLK_MAX) begin
                    status = ST_OVERFLOW;
                end else begin
                    blk_next   = blk_reg + BLK_W'(1);
                    armed_next = 1'b0;
                end
            end
            CMD_RELEASE: begin
                if (blk_reg == '0) begin
                    status = ST_INVAL;
                end else begin
                    blk_next = blk_reg - BLK_W'(1);
                    if (wait_reg != '0 && held_reg == '0 && blk_next == '0) begin
                        armed_next = 1'b1;
                        cnt_next   = idle_ticks_reg;
                    end
                end
            end
            CMD_TICK: begin
                if (armed_reg) begin
                    if (cnt_reg <= TICKS_W'(1)) begin
                        armed_next = 1'b0;
                        cnt_next   = '0;
                        if (wait_reg != '0 && held_reg == '0 && blk_reg == '0) begin
                            cur_next  = wait_reg;
                            wait_next = '0;
                            committed = 1'b1;
                        end
                    end else begin
                        cnt_next = cnt_reg - TICKS_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.status_code       = status;
        result.live_generation   = cur_next;
        result.queued_generation = wait_next;
        result.pressed_count     = held_next;
        result.blocker_total     = blk_next;
        result.timer_running     = armed_next;
        result.committed         = committed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_ticks_reg <= IDLE_TICKS_RESET;
            key_map_reg    <= '0;
            held_reg       <= '0;
            blk_reg        <= '0;
            wait_reg       <= '0;
            cur_reg        <= '0;
            armed_reg      <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_we) begin
                idle_ticks_reg <= cfg_data;
            end
            if (fire) begin
                if (map_we) begin
                    key_map_reg[key_idx] <= map_bit_next;
                end
                held_reg  <= held_next;
                blk_reg   <= blk_next;
                wait_reg  <= wait_next;
                cur_reg   <= cur_next;
                armed_reg <= armed_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule
